FILE: hw/rtl/multiply_with_carry_random_range_macros.svh
`ifndef MULTIPLY_WITH_CARRY_RANDOM_RANGE_MACROS_SVH
`define MULTIPLY_WITH_CARRY_RANDOM_RANGE_MACROS_SVH

`ifndef ASSERT_OFF

// checked only while out of reset
`define MWCR_ASSERT_RST(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("mwcr assertion failed");

// checked on every rising clock edge
`define MWCR_ASSERT_ALL(label, clk, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("mwcr assertion failed");

`else

`define MWCR_ASSERT_RST(label, clk, rst_n, prop)

`define MWCR_ASSERT_ALL(label, clk, prop)

`endif

`endif

FILE: hw/rtl/mwcr_pkg.sv
package mwcr_pkg;

  localparam logic [31:0] RESET_X_WORD = 32'd521288629;
  localparam logic [31:0] RESET_Y_WORD = 32'd362436069;
  localparam logic [15:0] RESET_MULT_X = 16'd18000;
  localparam logic [15:0] RESET_MULT_Y = 16'd30903;

  localparam logic ACT_DRAW = 1'b0;
  localparam logic ACT_SEED = 1'b1;

  // remainder steps, one quotient bit each
  localparam int DIV_STEPS = 31;
  localparam int CNT_W     = $clog2(DIV_STEPS);

  typedef enum logic [1:0] {
    REG_MULT_X,
    REG_MULT_Y,
    REG_RANGE_LOW,
    REG_RANGE_HIGH
  } reg_idx_t;

  typedef enum logic [1:0] {
    K_SEED,
    K_ERR,
    K_NEG,
    K_DIV
  } item_kind_t;

  typedef struct packed {
    item_kind_t  kind;
    logic [31:0] raw;
    logic [30:0] dvd;
  } q_entry_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_DIV,
    BK_ADD,
    BK_OUT
  } bk_state_t;

  typedef struct packed {
    logic busy;
    logic dividing;
  } bk_status_t;

  function automatic logic [31:0] mwc_step(input logic [31:0] word, input logic [15:0] mult);
    logic [31:0] prod;
    prod = {16'b0, mult} * {16'b0, word[15:0]};
    return prod + {16'b0, word[31:16]};
  endfunction

endpackage

FILE: hw/rtl/mwcr_if.sv
interface mwcr_in_if;
  logic        valid;
  logic        ready;
  logic        action;
  logic [31:0] seed_x;
  logic [31:0] seed_y;

  modport source (output valid, action, seed_x, seed_y, input ready);
  modport sink (input valid, action, seed_x, seed_y, output ready);
endinterface

interface mwcr_out_if;
  logic               valid;
  logic               ready;
  logic        [31:0] raw_value;
  logic signed [31:0] bounded_value;
  logic               range_error;

  modport source (output valid, raw_value, bounded_value, range_error, input ready);
  modport sink (input valid, raw_value, bounded_value, range_error, output ready);
endinterface

FILE: hw/rtl/mwcr_front.sv
module mwcr_front import mwcr_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  mwcr_in_if.sink     in_ch,
  input  logic [15:0] mult_x,
  input  logic [15:0] mult_y,
  input  logic [30:0] range_low,
  input  logic [30:0] range_high,
  input  q_status_t   q_st,
  output logic        q_push,
  output q_entry_t    q_wdata
);

  logic [31:0] x_word_r, x_word_nxt;
  logic [31:0] y_word_r, y_word_nxt;
  logic [31:0] x_step, y_step;
  logic [31:0] raw;
  logic        inverted;
  logic        acc;

  assign in_ch.ready = !q_st.full;
  assign acc         = in_ch.valid && in_ch.ready;
  assign q_push      = acc;

  assign x_step   = mwc_step(x_word_r, mult_x);
  assign y_step   = mwc_step(y_word_r, mult_y);
  assign raw      = {x_step[15:0], y_step[15:0]};
  assign inverted = $signed(range_high) < $signed(range_low);

  // classify the beat for the back end
  always_comb begin
    q_wdata.raw = raw;
    q_wdata.dvd = raw[31:1] - 31'd1;
    if (in_ch.action == ACT_SEED) begin
      q_wdata.kind = K_SEED;
      q_wdata.raw  = '0;
    end else if (inverted) begin
      q_wdata.kind = K_ERR;
    end else if (raw[31:1] == 31'd0) begin
      q_wdata.kind = K_NEG;
    end else begin
      q_wdata.kind = K_DIV;
    end
  end

  always_comb begin
    x_word_nxt = x_word_r;
    y_word_nxt = y_word_r;
    if (acc) begin
      if (in_ch.action == ACT_SEED) begin
        if (in_ch.seed_x != 32'd0) x_word_nxt = in_ch.seed_x;
        if (in_ch.seed_y != 32'd0) y_word_nxt = in_ch.seed_y;
      end else begin
        x_word_nxt = x_step;
        y_word_nxt = y_step;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      x_word_r <= RESET_X_WORD;
      y_word_r <= RESET_Y_WORD;
    end else begin
      x_word_r <= x_word_nxt;
      y_word_r <= y_word_nxt;
    end
  end

endmodule

FILE: hw/rtl/mwcr_queue.sv
module mwcr_queue import mwcr_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push,
  input  q_entry_t  wdata,
  input  logic      pop,
  output q_entry_t  rdata,
  output q_status_t st
);

  q_entry_t   mem [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       do_push, do_pop;

  assign st.full  = cnt_r == 2'd2;
  assign st.empty = cnt_r == 2'd0;
  assign do_push  = push && !st.full;
  assign do_pop   = pop && !st.empty;
  assign rdata    = mem[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = do_push ? !wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = do_pop ? !rd_ptr_r : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push && !do_pop) cnt_nxt = cnt_r + 2'd1;
    if (do_pop && !do_push) cnt_nxt = cnt_r - 2'd1;
  end

  always_ff @(posedge clk) begin
    if (do_push) mem[wr_ptr_r] <= wdata;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

endmodule

FILE: hw/rtl/mwcr_back.sv
module mwcr_back import mwcr_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic [30:0] range_low,
  input  logic [30:0] range_high,
  input  q_status_t   q_st,
  input  q_entry_t    q_rdata,
  output logic        q_pop,
  output bk_status_t  st,
  mwcr_out_if.source  out_ch
);

  bk_state_t          state_r, state_nxt;
  logic [31:0]        rem_r, rem_nxt;
  logic [30:0]        dvd_r, dvd_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic [31:0]        raw_r, raw_nxt;
  logic [31:0]        bnd_r, bnd_nxt;
  logic               err_r, err_nxt;
  logic [31:0]        lo_ext, hi_ext, span;
  logic [31:0]        trial, rem_step;

  assign lo_ext = {range_low[30], range_low};
  assign hi_ext = {range_high[30], range_high};
  assign span   = hi_ext - lo_ext + 32'd1;

  // one restoring remainder step
  assign trial    = {rem_r[30:0], dvd_r[30]};
  assign rem_step = (trial >= span) ? trial - span : trial;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      BK_IDLE: begin
        if (!q_st.empty) state_nxt = (q_rdata.kind == K_DIV) ? BK_DIV : BK_OUT;
      end
      BK_DIV: begin
        if (cnt_r == '0) state_nxt = BK_ADD;
      end
      BK_ADD: state_nxt = BK_OUT;
      BK_OUT: begin
        if (out_ch.ready) state_nxt = BK_IDLE;
      end
      default: state_nxt = BK_IDLE;
    endcase
  end

  always_comb begin
    q_pop       = (state_r == BK_IDLE) && !q_st.empty;
    out_ch.valid = state_r == BK_OUT;
    st.busy     = state_r != BK_IDLE;
    st.dividing = state_r == BK_DIV;
  end

  always_comb begin
    rem_nxt = rem_r;
    dvd_nxt = dvd_r;
    cnt_nxt = cnt_r;
    raw_nxt = raw_r;
    bnd_nxt = bnd_r;
    err_nxt = err_r;
    case (state_r)
      BK_IDLE: begin
        if (!q_st.empty) begin
          raw_nxt = q_rdata.raw;
          err_nxt = 1'b0;
          rem_nxt = '0;
          dvd_nxt = q_rdata.dvd;
          cnt_nxt = CNT_W'(DIV_STEPS - 1);
          case (q_rdata.kind)
            K_SEED: bnd_nxt = '0;
            K_ERR: begin
              bnd_nxt = lo_ext;
              err_nxt = 1'b1;
            end
            K_NEG: bnd_nxt = (span == 32'd1) ? lo_ext : lo_ext - 32'd1;
            default: bnd_nxt = '0;
          endcase
        end
      end
      BK_DIV: begin
        rem_nxt = rem_step;
        dvd_nxt = {dvd_r[29:0], 1'b0};
        cnt_nxt = cnt_r - CNT_W'(1);
      end
      BK_ADD: bnd_nxt = rem_r + lo_ext;
      default: ;
    endcase
  end

  assign out_ch.raw_value     = raw_r;
  assign out_ch.bounded_value = bnd_r;
  assign out_ch.range_error   = err_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= BK_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    dvd_r <= dvd_nxt;
    cnt_r <= cnt_nxt;
    raw_r <= raw_nxt;
    bnd_r <= bnd_nxt;
    err_r <= err_nxt;
  end

endmodule

FILE: hw/rtl/multiply_with_carry_random_range.sv
// channel  | dir | handshake        | payload
// in_ch    | in  | valid/ready      | action, seed_x, seed_y
// out_ch   | out | valid/ready      | raw_value, bounded_value, range_error
// apb      | in  | psel/penable     | paddr, pwdata, prdata
//
// a draw beat runs the 31-step remainder loop in the back end, then adds the range low
// seed beats, inverted ranges and raw values below 2 skip the loop and go straight to output
// the front takes a beat per cycle while the 2-entry queue has room
// synchronous reset restores multipliers, range and generator words
// a stalled result holds its register; the front keeps filling the queue
`include "multiply_with_carry_random_range_macros.svh"

module multiply_with_carry_random_range import mwcr_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  mwcr_in_if.sink     in_ch,
  mwcr_out_if.source  out_ch,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [15:0] mult_x_r, mult_x_nxt;
  logic [15:0] mult_y_r, mult_y_nxt;
  logic [30:0] range_low_r, range_low_nxt;
  logic [30:0] range_high_r, range_high_nxt;
  reg_idx_t    reg_idx;
  logic        cfg_wr;

  q_status_t   q_st;
  q_entry_t    q_wdata, q_rdata;
  logic        q_push, q_pop;
  bk_status_t  bk_st;

  assign pready  = 1'b1;
  assign reg_idx = reg_idx_t'(paddr[3:2]);
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_comb begin
    mult_x_nxt     = mult_x_r;
    mult_y_nxt     = mult_y_r;
    range_low_nxt  = range_low_r;
    range_high_nxt = range_high_r;
    if (cfg_wr) begin
      case (reg_idx)
        REG_MULT_X:     mult_x_nxt     = pwdata[15:0];
        REG_MULT_Y:     mult_y_nxt     = pwdata[15:0];
        REG_RANGE_LOW:  range_low_nxt  = pwdata[30:0];
        REG_RANGE_HIGH: range_high_nxt = pwdata[30:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_MULT_X:     prdata = {16'b0, mult_x_r};
      REG_MULT_Y:     prdata = {16'b0, mult_y_r};
      REG_RANGE_LOW:  prdata = {1'b0, range_low_r};
      REG_RANGE_HIGH: prdata = {1'b0, range_high_r};
      default:        prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mult_x_r     <= RESET_MULT_X;
      mult_y_r     <= RESET_MULT_Y;
      range_low_r  <= '0;
      range_high_r <= '0;
    end else begin
      mult_x_r     <= mult_x_nxt;
      mult_y_r     <= mult_y_nxt;
      range_low_r  <= range_low_nxt;
      range_high_r <= range_high_nxt;
    end
  end

  mwcr_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .mult_x     (mult_x_r),
    .mult_y     (mult_y_r),
    .range_low  (range_low_r),
    .range_high (range_high_r),
    .q_st       (q_st),
    .q_push     (q_push),
    .q_wdata    (q_wdata)
  );

  mwcr_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .wdata (q_wdata),
    .pop   (q_pop),
    .rdata (q_rdata),
    .st    (q_st)
  );

  mwcr_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .range_low  (range_low_r),
    .range_high (range_high_r),
    .q_st       (q_st),
    .q_rdata    (q_rdata),
    .q_pop      (q_pop),
    .st         (bk_st),
    .out_ch     (out_ch)
  );

  `MWCR_ASSERT_ALL(a_no_push_when_full, clk, !(q_push && q_st.full))
  `MWCR_ASSERT_RST(a_beat_reaches_queue, clk, rst_n, q_push |=> !q_st.empty)
  `MWCR_ASSERT_RST(a_no_result_while_dividing, clk, rst_n, !(bk_st.dividing && out_ch.valid))
  `MWCR_ASSERT_RST(a_pop_only_when_idle, clk, rst_n, q_pop |-> !bk_st.busy)

endmodule

FILE: bench/mwcr_checker.sv
module mwcr_checker import mwcr_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  mwcr_in_if          in_ch,
  mwcr_out_if         out_ch,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic        pready,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output int          fail_count,
  output int          pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [31:0]        raw;
    logic signed [31:0] bounded;
    logic               err;
  } draw_result_t;

  draw_result_t expected_q[$];
  int fails = 0;

  logic [31:0]        gen_x;
  logic [31:0]        gen_y;
  logic [15:0]        mult_x;
  logic [15:0]        mult_y;
  logic signed [30:0] range_lo;
  logic signed [30:0] range_hi;

  assign fail_count = fails;

  initial pending = 0;

  function automatic draw_result_t next_draw(input logic act, input logic [31:0] sx,
                                             input logic [31:0] sy);
    draw_result_t res;
    logic [63:0]  prod;
    longint       lo;
    longint       hi;
    longint       span;
    longint       r;
    longint       bounded;
    res = '0;
    if (act == ACT_SEED) begin
      if (sx != '0) gen_x = sx;
      if (sy != '0) gen_y = sy;
      return res;
    end
    prod = 64'(mult_x) * 64'(gen_x[15:0]) + 64'(gen_x[31:16]);
    gen_x = prod[31:0];
    prod = 64'(mult_y) * 64'(gen_y[15:0]) + 64'(gen_y[31:16]);
    gen_y = prod[31:0];
    res.raw = {gen_x[15:0], gen_y[15:0]};
    lo = range_lo;
    hi = range_hi;
    if (hi < lo) begin
      res.err = 1'b1;
      bounded = lo;
    end else begin
      span = hi - lo + 1;
      r = longint'({33'b0, res.raw[31:1]}) - 1;
      bounded = r % span + lo;
    end
    res.bounded = bounded[31:0];
    return res;
  endfunction

  always @(posedge clk) begin
    draw_result_t got;
    draw_result_t want;
    if (!rst_n) begin
      gen_x = RESET_X_WORD;
      gen_y = RESET_Y_WORD;
      mult_x = RESET_MULT_X;
      mult_y = RESET_MULT_Y;
      range_lo = '0;
      range_hi = '0;
      expected_q.delete();
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (reg_idx_t'(paddr[3:2]))
          REG_MULT_X: mult_x = pwdata[15:0];
          REG_MULT_Y: mult_y = pwdata[15:0];
          REG_RANGE_LOW: range_lo = pwdata[30:0];
          REG_RANGE_HIGH: range_hi = pwdata[30:0];
          default: ;
        endcase
      end
      if (in_ch.valid && in_ch.ready)
        expected_q.push_back(next_draw(in_ch.action, in_ch.seed_x, in_ch.seed_y));
      if (out_ch.valid && out_ch.ready) begin
        got = '{out_ch.raw_value, out_ch.bounded_value, out_ch.range_error};
        if (expected_q.size() == 0) begin
          fails++;
          $display("%0t: unexpected result beat raw %h bounded %0d err %b", $time,
                   got.raw, got.bounded, got.err);
        end else begin
          want = expected_q.pop_front();
          if (got.raw !== want.raw) begin
            fails++;
            $display("%0t: raw_value expected %h actual %h", $time, want.raw, got.raw);
          end
          if (got.bounded !== want.bounded) begin
            fails++;
            $display("%0t: bounded_value expected %0d actual %0d", $time,
                     want.bounded, got.bounded);
          end
          if (got.err !== want.err) begin
            fails++;
            $display("%0t: range_error expected %b actual %b", $time, want.err, got.err);
          end
        end
      end
    end
    pending <= expected_q.size();
  end

endmodule

FILE: bench/tb_multiply_with_carry_random_range.sv
module tb_multiply_with_carry_random_range;
  import mwcr_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RANGE_MIN = -1073741824;
  localparam int RANGE_MAX = 1073741823;
  localparam int HOLD_CYCLES = 300;

  logic        clk;
  logic        rst_n;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [3:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  int  send_idle;
  int  recv_idle;
  logic hold_req;
  logic hold_seen;
  int  hold_left;
  int  check_fails;
  int  results_owed;

  mwcr_in_if  in_ch();
  mwcr_out_if out_ch();

  multiply_with_carry_random_range u_top (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  mwcr_checker u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .out_ch     (out_ch),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .pready     (pready),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .fail_count (check_fails),
    .pending    (results_owed)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #20_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  // result side: random stalls plus a long hold-off on request
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      hold_seen <= hold_req;
      hold_left <= 0;
    end else if (hold_req != hold_seen) begin
      hold_seen <= hold_req;
      hold_left <= HOLD_CYCLES;
      out_ch.ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= ($urandom_range(0, 99) >= recv_idle);
    end
  end

  task automatic send_beat(input logic act, input logic [31:0] sx, input logic [31:0] sy);
    int gap;
    gap = 0;
    while ($urandom_range(0, 99) < send_idle) gap++;
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.action <= act;
    in_ch.seed_x <= sx;
    in_ch.seed_y <= sy;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (results_owed != 0);
  endtask

  task automatic write_reg(input reg_idx_t idx, input logic [31:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
  endtask

  task automatic set_config(input int mx, input int my, input int lo, input int hi);
    drain();
    write_reg(REG_MULT_X, mx);
    write_reg(REG_MULT_Y, my);
    write_reg(REG_RANGE_LOW, lo);
    write_reg(REG_RANGE_HIGH, hi);
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  function automatic int rand_bound();
    return int'($urandom_range(0, 32'h7FFF_FFFF)) + RANGE_MIN;
  endfunction

  function automatic int rand_mult();
    case ($urandom_range(0, 9))
      0: return 0;
      1: return 65535;
      2: return RESET_MULT_X;
      default: return $urandom_range(1, 65535);
    endcase
  endfunction

  task automatic random_config();
    int lo;
    int hi;
    int t;
    lo = rand_bound();
    hi = rand_bound();
    case ($urandom_range(0, 5))
      0, 1: begin
        hi = lo + $urandom_range(0, 1000);
        if (hi > RANGE_MAX) hi = RANGE_MAX;
      end
      2: begin
        if (hi < lo) begin
          t = lo;
          lo = hi;
          hi = t;
        end
      end
      3: begin
        if (lo == hi) hi = (lo == RANGE_MIN) ? RANGE_MAX : RANGE_MIN;
        if (hi > lo) begin
          t = lo;
          lo = hi;
          hi = t;
        end
      end
      4: begin
        lo = RANGE_MIN;
        hi = RANGE_MAX;
      end
      default: hi = lo;
    endcase
    set_config(rand_mult(), rand_mult(), lo, hi);
  endtask

  task automatic random_beat();
    logic [31:0] sx;
    logic [31:0] sy;
    sx = $urandom();
    sy = $urandom();
    if ($urandom_range(0, 3) == 0) sx = '0;
    if ($urandom_range(0, 3) == 0) sy = '0;
    if ($urandom_range(0, 9) == 0) send_beat(ACT_SEED, sx, sy);
    else send_beat(ACT_DRAW, sx, sy);
  endtask

  initial begin
    rst_n = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    in_ch.valid = 1'b0;
    in_ch.action = ACT_DRAW;
    in_ch.seed_x = '0;
    in_ch.seed_y = '0;
    out_ch.ready = 1'b0;
    hold_req = 1'b0;
    send_idle = 25;
    recv_idle = 84;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // reset settings, zero seeds keep the words
    send_beat(ACT_DRAW, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_beat(ACT_DRAW, '0, '0);
    send_beat(ACT_SEED, '0, '0);
    send_beat(ACT_DRAW, '0, '0);

    // zero multipliers force raw values of one and zero, then an all-ones raw value
    set_config(0, 0, -5, 10);
    send_beat(ACT_SEED, 32'h0000_0001, 32'h0001_0000);
    send_beat(ACT_DRAW, '0, '0);
    send_beat(ACT_SEED, 32'h0000_0001, 32'h0000_0001);
    send_beat(ACT_DRAW, '0, '0);
    send_beat(ACT_DRAW, '0, '0);
    send_beat(ACT_SEED, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_beat(ACT_DRAW, '0, '0);

    // widest range, largest multipliers
    set_config(65535, 65535, RANGE_MIN, RANGE_MAX);
    send_beat(ACT_SEED, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_beat(ACT_DRAW, '0, '0);
    send_beat(ACT_DRAW, '0, '0);
    send_beat(ACT_DRAW, '0, '0);

    // single value range with raw zero
    set_config(0, 0, 7, 7);
    send_beat(ACT_SEED, 32'h0000_0001, 32'h0000_0001);
    send_beat(ACT_DRAW, '0, '0);

    // inverted range
    set_config(RESET_MULT_X, RESET_MULT_Y, 100, -100);
    send_beat(ACT_DRAW, '0, '0);
    send_beat(ACT_SEED, 32'h1234_5678, 32'h9ABC_DEF0);
    send_beat(ACT_DRAW, 32'h5555_5555, 32'hAAAA_AAAA);

    set_config(1, 65535, RANGE_MAX, RANGE_MAX);
    send_beat(ACT_DRAW, '0, '0);
    set_config(65535, 1, RANGE_MIN, RANGE_MIN);
    send_beat(ACT_DRAW, '0, '0);

    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          send_idle = 25;
          recv_idle = 84;
        end
        1: begin
          send_idle = 84;
          recv_idle = 25;
        end
        default: begin
          send_idle = 0;
          recv_idle = 0;
        end
      endcase
      for (int chunk = 0; chunk < 3; chunk++) begin
        random_config();
        for (int i = 0; i < 210; i++) begin
          // long result stall while beats keep coming
          if (chunk == 0 && i == 60) hold_req <= ~hold_req;
          random_beat();
        end
      end
    end

    drain();
    repeat (40) @(posedge clk);
    if (check_fails == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

FILE: sim.f
+incdir+hw/rtl
hw/rtl/mwcr_pkg.sv
hw/rtl/mwcr_if.sv
hw/rtl/mwcr_front.sv
hw/rtl/mwcr_queue.sv
hw/rtl/mwcr_back.sv
hw/rtl/multiply_with_carry_random_range.sv
bench/mwcr_checker.sv
bench/tb_multiply_with_carry_random_range.sv
